### sv/aips_pkg.sv
// Shared types, codes and helpers for the alpha-in-RGB pixel swizzle unit.
// No dependencies; imported by every module of the block.
package aips_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 8;
  localparam logic [ChanW-1:0] AlphaThreshRst = 8'd127;

  typedef enum logic [1:0] {
    FMT_6666 = 2'd0,
    FMT_7773 = 2'd1,
    FMT_8871 = 2'd2,
    FMT_PASS = 2'd3
  } fmt_t;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_IDX_FORMAT = 2'd0,
    CFG_IDX_DIR    = 2'd1,
    CFG_IDX_THRESH = 2'd2,
    CFG_IDX_NONE   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [ChanW-1:0] chan0_in;
    logic [ChanW-1:0] chan1_in;
    logic [ChanW-1:0] chan2_in;
    logic [ChanW-1:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] chan0_out;
    logic [ChanW-1:0] chan1_out;
    logic [ChanW-1:0] chan2_out;
    logic [ChanW-1:0] alpha_out;
  } pix_out_t;

  typedef struct packed {
    fmt_t             fmt;
    dir_t             dir;
    logic [ChanW-1:0] thresh;
  } cfg_t;

  // (levels*x + 127) / 255, levels <= 127: divide by 255 as shift plus one
  // correction step, remainder stays below twice the divisor.
  function automatic logic [6:0] scale_down(input logic [ChanW-1:0] x,
                                            input logic [6:0] levels);
    logic [14:0] y;
    logic [6:0]  q0;
    logic [8:0]  rem;
    y   = 15'(levels) * 15'(x) + 15'd127;
    q0  = y[14:8];
    rem = 9'(y[7:0]) + 9'(q0);
    return q0 + 7'(rem >= 9'd255);
  endfunction

endpackage

### sv/aips_cfg_regs.sv
// Configuration registers of the pixel swizzle unit.
// Depends on aips_pkg.
module aips_cfg_regs import aips_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                cfg
);

  fmt_t             fmt_r;
  dir_t             dir_r;
  logic [ChanW-1:0] thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_6666;
      dir_r    <= DIR_ENCODE;
      thresh_r <= AlphaThreshRst;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_IDX_FORMAT: fmt_r    <= fmt_t'(cfg_wdata[1:0]);
        CFG_IDX_DIR:    dir_r    <= dir_t'(cfg_wdata[0]);
        CFG_IDX_THRESH: thresh_r <= cfg_wdata[ChanW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{fmt: fmt_r, dir: dir_r, thresh: thresh_r};

endmodule

### sv/aips_recode.sv
// Combinational pixel recoder: alpha packing into colour bits and back, or pass-through.
// Depends on aips_pkg (types, codes, scale_down).
module aips_recode import aips_pkg::*; (
  input  cfg_t     cfg,
  input  pix_in_t  pix_i,
  output pix_out_t pix_o
);

  logic [6:0] a6, a3, c0_6, c1_6, c2_6, c0_7, c1_7, c2_7;
  logic [ChanW-1:0] c0, c1, c2, a;

  assign c0 = pix_i.chan0_in;
  assign c1 = pix_i.chan1_in;
  assign c2 = pix_i.chan2_in;
  assign a  = pix_i.alpha_in;

  assign a6   = scale_down(a, 7'd63);
  assign a3   = scale_down(a, 7'd7);
  assign c0_6 = scale_down(c0, 7'd63);
  assign c1_6 = scale_down(c1, 7'd63);
  assign c2_6 = scale_down(c2, 7'd63);
  assign c0_7 = scale_down(c0, 7'd127);
  assign c1_7 = scale_down(c1, 7'd127);
  assign c2_7 = scale_down(c2, 7'd127);

  always_comb begin
    pix_o = '{chan0_out: c0, chan1_out: c1, chan2_out: c2, alpha_out: a};
    unique case (cfg.fmt)
      FMT_6666: begin
        if (cfg.dir == DIR_ENCODE) begin
          pix_o.chan0_out = {a6[1:0], c0_6[5:0]};
          pix_o.chan1_out = {a6[3:2], c1_6[5:0]};
          pix_o.chan2_out = {a6[5:4], c2_6[5:0]};
        end else begin
          pix_o.chan0_out = {c0[5:0], 2'b00};
          pix_o.chan1_out = {c1[5:0], 2'b00};
          pix_o.chan2_out = {c2[5:0], 2'b00};
          pix_o.alpha_out = {c2[7:6], c1[7:6], c0[7:6], 2'b00};
        end
      end
      FMT_7773: begin
        if (cfg.dir == DIR_ENCODE) begin
          pix_o.chan0_out = {a3[0], c0_7};
          pix_o.chan1_out = {a3[1], c1_7};
          pix_o.chan2_out = {a3[2], c2_7};
        end else begin
          pix_o.chan0_out = {c0[6:0], 1'b0};
          pix_o.chan1_out = {c1[6:0], 1'b0};
          pix_o.chan2_out = {c2[6:0], 1'b0};
          pix_o.alpha_out = {c2[7], c1[7], c0[7], 5'b00000};
        end
      end
      FMT_8871: begin
        if (cfg.dir == DIR_ENCODE) begin
          pix_o.chan2_out = {(a > cfg.thresh), c2_7};
        end else begin
          pix_o.chan2_out = {c2[6:0], 1'b0};
          pix_o.alpha_out = {ChanW{c2[7]}};
        end
      end
      FMT_PASS: ;
      default: ;
    endcase
  end

endmodule

### sv/alpha_in_rgb_pixel_swizzle_unit.sv
// Top level of the alpha-in-RGB pixel swizzle unit: input register, recoder,
// result register. Depends on aips_pkg, aips_cfg_regs, aips_recode.
//
//   channel  dir  handshake             word
//   in_      in   in_valid / in_ready   pix_in_t  in_data
//   out_     out  out_valid / out_ready pix_out_t out_data
//   cfg_     in   cfg_we                cfg_addr, cfg_wdata
//
// One word per cycle sustained while out_ready stays high; each word passes the input
// register, then the result register, with the recoder logic in between.
// Synchronous active-low reset empties both stages and loads register defaults.
// A stall on out_ready holds the result; the input stage still takes one more
// word while it is empty, and in_ready follows out_ready when both are full.
module alpha_in_rgb_pixel_swizzle_unit import aips_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pix_in_t             in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pix_out_t            out_data,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t     cfg;
  pix_in_t  in_word_r;
  logic     in_vld_r;
  pix_out_t res_nxt;
  pix_out_t out_word_r;
  logic     out_vld_r;
  logic     out_adv;

  aips_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  aips_recode u_recode (
    .cfg   (cfg),
    .pix_i (in_word_r),
    .pix_o (res_nxt)
  );

  assign out_adv  = !out_vld_r || out_ready;
  assign in_ready = !in_vld_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (out_adv) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_word_r <= in_data;
    end
    if (out_adv && in_vld_r) begin
      out_word_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_word_r;

endmodule

### sv/aips_checker.sv
// Port-level checks for the pixel swizzle unit, bound to the top level.
// Depends on aips_pkg and alpha_in_rgb_pixel_swizzle_unit.
module aips_checker import aips_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input pix_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted word did not reach the result register");

endmodule

bind alpha_in_rgb_pixel_swizzle_unit aips_checker u_aips_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
